// ===== src/gld_pkg.sv =====
// Shared types and constants of the GIF LZW decoder.
package gld_pkg;

    localparam int TABLE_ENTRIES_DEF = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int CODE_W            = 12;
    localparam int CNT_W             = 29;
    localparam int PTR_W             = 13;

    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_FEED  = 2'd1;
    localparam logic [1:0] ACT_END   = 2'd2;
    localparam logic [1:0] ACT_PULL  = 2'd3;

    localparam logic CFG_ROOT     = 1'b0;
    localparam logic CFG_EXPECTED = 1'b1;

    typedef enum logic [2:0] {
        ST_SYMBOL   = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_REFUSED  = 3'd2,
        ST_NEED     = 3'd3,
        ST_DONE     = 3'd4,
        ST_BAD      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        OUT_RUNNING = 2'd0,
        OUT_DONE    = 2'd1,
        OUT_BAD     = 2'd2
    } t_outcome;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_START, OP_FEED, OP_ENDD, OP_TAKE, OP_CLEAR,
        OP_LIT, OP_WINIT, OP_WPUSH, OP_LAST, OP_FAIL, OP_FINISH, OP_POP
    } t_op;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]       symbol;
        logic [2:0]       status;
        logic [CNT_W-1:0] symbols_so_far;
    } t_out;

    typedef struct packed {
        t_op     op;
        logic    emit;
        t_status st;
    } t_cmd;

    typedef struct packed {
        logic [1:0] action;
        t_outcome   outcome;
        logic       out_valid;
        logic       feed_refuse;
        logic       stack_empty;
        logic       root_ok;
        logic       bits_short;
        logic       end_seen;
        logic       finish_ok;
        logic       code_is_clear;
        logic       code_is_end;
        logic       prev_valid;
        logic       code_ge_clear;
        logic       code_gt_next;
        logic       walk_ge_clear;
        logic       walk_bad;
        logic       sp_full;
        logic       pop_bad;
    } t_dp_stat;

endpackage

// ===== src/gld_ctrl.sv =====
// Controller state machine of the GIF LZW decoder.
module gld_ctrl import gld_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_cmd     o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_ACT, S_DCHK, S_DCODE, S_WINIT, S_WRD, S_WDAT, S_LAST, S_POPCHK, S_SYM
    } t_state;

    t_state r_state, n_state;
    t_cmd   n_cmd;

    assign o_in_ready = (r_state == S_IDLE) && (!i_stat.out_valid || i_out_ready);
    assign o_cmd      = n_cmd;

    // Sequence one item: decide, decode codes, walk the chain, pop
    always_comb begin
        n_state = r_state;
        n_cmd   = '{op: OP_NONE, emit: 1'b0, st: ST_ACCEPTED};
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_cmd.op = OP_LOAD;
                    n_state  = S_ACT;
                end
            end
            S_ACT: begin
                n_state = S_IDLE;
                case (i_stat.action)
                    ACT_START: begin
                        n_cmd = '{op: OP_START, emit: 1'b1, st: ST_ACCEPTED};
                    end
                    ACT_FEED: begin
                        if (i_stat.feed_refuse) begin
                            n_cmd = '{op: OP_NONE, emit: 1'b1, st: ST_REFUSED};
                        end else begin
                            n_cmd = '{op: OP_FEED, emit: 1'b1, st: ST_ACCEPTED};
                        end
                    end
                    ACT_END: begin
                        n_cmd = '{op: OP_ENDD, emit: 1'b1, st: ST_ACCEPTED};
                    end
                    default: begin
                        if (i_stat.outcome == OUT_DONE) begin
                            n_cmd = '{op: OP_NONE, emit: 1'b1, st: ST_DONE};
                        end else if (i_stat.outcome == OUT_BAD) begin
                            n_cmd = '{op: OP_NONE, emit: 1'b1, st: ST_BAD};
                        end else if (i_stat.stack_empty) begin
                            n_state = S_DCHK;
                        end else begin
                            n_state = S_POPCHK;
                        end
                    end
                endcase
            end
            S_DCHK: begin
                if (!i_stat.root_ok) begin
                    n_cmd   = '{op: OP_FAIL, emit: 1'b1, st: ST_BAD};
                    n_state = S_IDLE;
                end else if (i_stat.bits_short) begin
                    n_state = S_IDLE;
                    if (i_stat.end_seen) begin
                        n_cmd = '{op: OP_FINISH, emit: 1'b1,
                                  st: i_stat.finish_ok ? ST_DONE : ST_BAD};
                    end else begin
                        n_cmd = '{op: OP_NONE, emit: 1'b1, st: ST_NEED};
                    end
                end else begin
                    n_cmd.op = OP_TAKE;
                    n_state  = S_DCODE;
                end
            end
            S_DCODE: begin
                if (i_stat.code_is_clear) begin
                    n_cmd.op = OP_CLEAR;
                    n_state  = S_DCHK;
                end else if (i_stat.code_is_end) begin
                    n_cmd   = '{op: OP_FINISH, emit: 1'b1,
                                st: i_stat.finish_ok ? ST_DONE : ST_BAD};
                    n_state = S_IDLE;
                end else if (!i_stat.prev_valid) begin
                    if (i_stat.code_ge_clear) begin
                        n_cmd   = '{op: OP_FAIL, emit: 1'b1, st: ST_BAD};
                        n_state = S_IDLE;
                    end else begin
                        n_cmd.op = OP_LIT;
                        n_state  = S_POPCHK;
                    end
                end else if (i_stat.code_gt_next) begin
                    n_cmd   = '{op: OP_FAIL, emit: 1'b1, st: ST_BAD};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_WINIT;
                end
            end
            S_WINIT: begin
                n_cmd.op = OP_WINIT;
                n_state  = S_WRD;
            end
            S_WRD: begin
                if (i_stat.walk_ge_clear) begin
                    if (i_stat.walk_bad) begin
                        n_cmd   = '{op: OP_FAIL, emit: 1'b1, st: ST_BAD};
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_WDAT;
                    end
                end else if (i_stat.sp_full) begin
                    n_cmd   = '{op: OP_FAIL, emit: 1'b1, st: ST_BAD};
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LAST;
                end
            end
            S_WDAT: begin
                n_cmd.op = OP_WPUSH;
                n_state  = S_WRD;
            end
            S_LAST: begin
                n_cmd.op = OP_LAST;
                n_state  = S_POPCHK;
            end
            S_POPCHK: begin
                if (i_stat.pop_bad) begin
                    n_cmd   = '{op: OP_FAIL, emit: 1'b1, st: ST_BAD};
                    n_state = S_IDLE;
                end else begin
                    n_cmd.op = OP_POP;
                    n_state  = S_SYM;
                end
            end
            S_SYM: begin
                n_cmd   = '{op: OP_NONE, emit: 1'b1, st: ST_SYMBOL};
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/gld_datapath.sv =====
// Datapath of the GIF LZW decoder: bit buffer, code tables, string stack, result register.
module gld_datapath import gld_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_in              i_in_data,
    input  logic             i_out_ready,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CNT_W-1:0] i_cfg_data,
    output t_dp_stat         o_stat,
    output logic             o_out_valid,
    output t_out             o_out_data
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam logic [PTR_W-1:0] TE = PTR_W'(TABLE_ENTRIES);
    localparam logic [3:0] MAXW = 4'(MAX_CODE_BITS);

    logic [CODE_W-1:0] r_prefix [TABLE_ENTRIES];
    logic [7:0]        r_suffix [TABLE_ENTRIES];
    logic [7:0]        r_stack  [TABLE_ENTRIES];
    logic [CODE_W-1:0] r_pre_q;
    logic [7:0]        r_suf_q, r_stack_q;

    logic [3:0]        r_root;
    logic [CNT_W-1:0]  r_expected;
    t_in               r_in;
    logic [PTR_W-1:0]  r_depth, r_next, r_sp;
    logic [3:0]        r_width;
    logic [CODE_W-1:0] r_prev, r_code, r_walk;
    logic              r_prev_valid, r_end_seen;
    logic [7:0]        r_first;
    logic [31:0]       r_buf;
    logic [5:0]        r_count;
    logic [CNT_W-1:0]  r_sym_cnt;
    t_outcome          r_outcome;
    logic              r_out_valid;
    t_out              r_out;

    logic              root_ok;
    logic [PTR_W-1:0]  clr_val, next_inc;
    logic [3:0]        start_root;
    logic [31:0]       take_mask;
    logic              code_ge_next;
    logic              stk_we;
    logic [AW-1:0]     stk_wa;
    logic [7:0]        stk_wd;
    logic              tab_we;
    logic [PTR_W-1:0]  depth_m1;

    assign root_ok    = (r_root >= 4'd2) && (r_root <= 4'd8) && (r_root < MAXW);
    assign clr_val    = PTR_W'(1) << r_root;
    assign start_root = root_ok ? r_root : 4'd8;
    assign take_mask  = (32'd1 << r_width) - 32'd1;
    assign code_ge_next = {1'b0, r_code} >= r_next;
    assign next_inc   = r_next + PTR_W'(1);
    assign tab_we     = (i_cmd.op == OP_LAST) && (r_next < TE);
    assign depth_m1   = r_depth - PTR_W'(1);

    // Report status flags to the controller
    always_comb begin
        o_stat.action        = r_in.action;
        o_stat.outcome       = r_outcome;
        o_stat.out_valid     = r_out_valid;
        o_stat.feed_refuse   = r_end_seen || (r_count > 6'd24);
        o_stat.stack_empty   = (r_depth == '0);
        o_stat.root_ok       = root_ok;
        o_stat.bits_short    = r_count < {2'b00, r_width};
        o_stat.end_seen      = r_end_seen;
        o_stat.finish_ok     = (r_sym_cnt == r_expected);
        o_stat.code_is_clear = ({1'b0, r_code} == clr_val);
        o_stat.code_is_end   = ({1'b0, r_code} == clr_val + PTR_W'(1));
        o_stat.prev_valid    = r_prev_valid;
        o_stat.code_ge_clear = ({1'b0, r_code} >= clr_val);
        o_stat.code_gt_next  = ({1'b0, r_code} > r_next);
        o_stat.walk_ge_clear = ({1'b0, r_walk} >= clr_val);
        o_stat.walk_bad      = (r_sp >= TE) || ({1'b0, r_walk} >= TE);
        o_stat.sp_full       = (r_sp >= TE);
        o_stat.pop_bad       = (r_sym_cnt >= r_expected) || (r_depth == '0) || (r_depth > TE);
    end

    // Select the stack write
    always_comb begin
        stk_we = 1'b0;
        stk_wa = r_sp[AW-1:0];
        stk_wd = r_walk[7:0];
        case (i_cmd.op)
            OP_LIT: begin
                stk_we = 1'b1;
                stk_wa = '0;
                stk_wd = r_code[7:0];
            end
            OP_WINIT: begin
                stk_we = code_ge_next;
                stk_wa = '0;
                stk_wd = r_first;
            end
            OP_WPUSH: begin
                stk_we = 1'b1;
                stk_wd = r_suf_q;
            end
            OP_LAST: begin
                stk_we = 1'b1;
            end
            default: begin
                stk_we = 1'b0;
            end
        endcase
    end

    // Write and read the string stack
    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stack[stk_wa] <= stk_wd;
        end
        r_stack_q <= r_stack[depth_m1[AW-1:0]];
    end

    // Write and read the prefix and suffix tables
    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_prefix[r_next[AW-1:0]] <= r_prev;
            r_suffix[r_next[AW-1:0]] <= r_walk[7:0];
        end
        r_pre_q <= r_prefix[r_walk[AW-1:0]];
        r_suf_q <= r_suffix[r_walk[AW-1:0]];
    end

    // Latch input and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_in <= i_in_data;
        end
        if (i_cmd.op == OP_TAKE) begin
            r_code <= r_buf[CODE_W-1:0] & take_mask[CODE_W-1:0];
        end
        if (i_cmd.op == OP_WINIT) begin
            r_walk <= code_ge_next ? r_prev : r_code;
            r_sp   <= code_ge_next ? PTR_W'(1) : PTR_W'(0);
        end
        if (i_cmd.op == OP_WPUSH) begin
            r_walk <= r_pre_q;
            r_sp   <= r_sp + PTR_W'(1);
        end
    end

    // Update decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root       <= 4'd8;
            r_expected   <= CNT_W'(1);
            r_depth      <= '0;
            r_width      <= 4'd9;
            r_next       <= PTR_W'(258);
            r_prev       <= '0;
            r_prev_valid <= 1'b0;
            r_first      <= '0;
            r_buf        <= '0;
            r_count      <= '0;
            r_sym_cnt    <= '0;
            r_end_seen   <= 1'b0;
            r_outcome    <= OUT_RUNNING;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ROOT) begin
                    r_root <= i_cfg_data[3:0];
                end else begin
                    r_expected <= i_cfg_data;
                end
            end
            case (i_cmd.op)
                OP_START: begin
                    r_depth      <= '0;
                    r_width      <= start_root + 4'd1;
                    r_next       <= (PTR_W'(1) << start_root) + PTR_W'(2);
                    r_prev       <= '0;
                    r_prev_valid <= 1'b0;
                    r_first      <= '0;
                    r_buf        <= '0;
                    r_count      <= '0;
                    r_sym_cnt    <= '0;
                    r_end_seen   <= 1'b0;
                    r_outcome    <= root_ok ? OUT_RUNNING : OUT_BAD;
                end
                OP_FEED: begin
                    r_buf   <= r_buf | ({24'd0, r_in.data_byte} << r_count);
                    r_count <= r_count + 6'd8;
                end
                OP_ENDD: begin
                    r_end_seen <= 1'b1;
                end
                OP_TAKE: begin
                    r_buf   <= r_buf >> r_width;
                    r_count <= r_count - {2'b00, r_width};
                end
                OP_CLEAR: begin
                    r_width      <= r_root + 4'd1;
                    r_next       <= clr_val + PTR_W'(2);
                    r_prev_valid <= 1'b0;
                end
                OP_LIT: begin
                    r_first      <= r_code[7:0];
                    r_prev       <= r_code;
                    r_prev_valid <= 1'b1;
                    r_depth      <= PTR_W'(1);
                end
                OP_LAST: begin
                    r_first <= r_walk[7:0];
                    r_depth <= r_sp + PTR_W'(1);
                    r_prev  <= r_code;
                    if (r_next < TE) begin
                        r_next <= next_inc;
                        if ((r_width < MAXW) && (next_inc == (PTR_W'(1) << r_width))) begin
                            r_width <= r_width + 4'd1;
                        end
                    end
                end
                OP_FAIL: begin
                    r_outcome <= OUT_BAD;
                end
                OP_FINISH: begin
                    r_outcome <= (r_sym_cnt == r_expected) ? OUT_DONE : OUT_BAD;
                end
                OP_POP: begin
                    r_depth   <= depth_m1;
                    r_sym_cnt <= r_sym_cnt + CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the result until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Register each result; report a zero count for a start, which clears the count at the same edge
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out.symbol         <= (i_cmd.st == ST_SYMBOL) ? r_stack_q : 8'd0;
            r_out.status         <= i_cmd.st;
            r_out.symbols_so_far <= (i_cmd.op == OP_START) ? '0 : r_sym_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== src/gif_lzw_decoder_unit.sv =====
// GIF LZW decoder top level: controller and datapath.
// Each transfer on the input gives exactly one result. Start, feed and end give their
// result from the action state after the input transfer, through the result register.
// A pull that pops a waiting stack entry passes the pop check and symbol states; one that
// must decode takes each code, walks the prefix chain with one table read and one stack
// push per step and writes the new table entry for a string, so the latency grows with
// the length of the decoded string. The tables and the string stack are memories with
// one write port and one registered read port each and need no clearing pass.
module gif_lzw_decoder_unit import gld_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in              i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out             o_out_data,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_cmd     cmd;
    t_dp_stat stat;

    gld_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    gld_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
